// File: hw/rtl/mrd_pkg.sv
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types and constants of the receive deframer: byte roles, register
// indexes, reset values and the result word layout.
// ----------------------------------------------------------------------------
package mrd_pkg;

	localparam int unsigned CfgIdxW   = 1;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned LenW      = 28;
	localparam int unsigned CountW    = 16;

	localparam logic [CfgIdxW-1:0] CFG_MAX_TOPIC   = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 1'b1;

	localparam logic [CfgDataW-1:0] MAX_TOPIC_RST   = 16'd127;
	localparam logic [CfgDataW-1:0] MAX_PAYLOAD_RST = 16'd1023;

	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	typedef enum logic [2:0] {
		ROLE_HEADER   = 3'd0,
		ROLE_LENGTH   = 3'd1,
		ROLE_TLEN     = 3'd2,
		ROLE_TOPIC    = 3'd3,
		ROLE_PAYLOAD  = 3'd4,
		ROLE_BODY     = 3'd5,
		ROLE_DISCARD  = 3'd6
	} role_t;

	typedef struct packed {
		logic [7:0] data_byte;
		role_t      byte_role;
		logic [3:0] packet_type;
		logic       packet_end;
		logic       byte_kept;
		logic       malformed;
		logic       length_error;
	} result_t;

endpackage

// File: hw/rtl/mrd_in_if.sv
// ----------------------------------------------------------------------------
// mrd_in_if
// Input channel: one received byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// File: hw/rtl/mrd_out_if.sv
// ----------------------------------------------------------------------------
// mrd_out_if
// Output channel: one tagged byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [2:0] byte_role;
	logic [3:0] packet_type;
	logic       packet_end;
	logic       byte_kept;
	logic       malformed;
	logic       length_error;

	modport source (output valid, output data_byte, output byte_role, output packet_type,
		output packet_end, output byte_kept, output malformed, output length_error,
		input ready);
	modport sink (input valid, input data_byte, input byte_role, input packet_type,
		input packet_end, input byte_kept, input malformed, input length_error,
		output ready);
endinterface

// File: hw/rtl/mqtt_receive_deframer_core.sv
// ----------------------------------------------------------------------------
// mqtt_receive_deframer_core
// MQTT 3.1.1 receive deframer: tags each received byte with its role in the
// packet, decodes the remaining length and limits topic and payload bytes.
//
//   channel   dir   word                       handshake
//   rx        in    in_byte                    valid/ready
//   tx        out   tagged byte + flags        valid/ready
//   cfg_*     in    max_topic / max_payload    write enable, no wait
//
// one word per cycle sustained while tx takes words; rx reaches tx through stage 1 and the result register
// stage 1 registers the byte, the parser updates packet state as the byte
// moves into the result register
// a stalled tx holds both stages; rx ready drops only when both are full
// arst_n clears valids, packet state and loads the reset limits
// ----------------------------------------------------------------------------
module mqtt_receive_deframer_core import mrd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	mrd_in_if.sink              rx,
	mrd_out_if.source           tx,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic [CfgDataW-1:0] max_topic_q;
	logic [CfgDataW-1:0] max_payload_q;
	logic                advance;
	logic                step;
	result_t             res;

	assign rx.ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_topic_q   <= MAX_TOPIC_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_TOPIC:   max_topic_q   <= cfg_data;
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.in_byte     (byte_s1),
		.max_topic   (max_topic_q),
		.max_payload (max_payload_q),
		.res         (res)
	);

	mrd_result_reg u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (valid_s1),
		.d       (res),
		.advance (advance),
		.tx      (tx)
	);

endmodule

// File: hw/rtl/mrd_parser.sv
// ----------------------------------------------------------------------------
// mrd_parser
// Packet state of the deframer: classifies one byte per step, decodes the
// remaining length and walks topic and payload of PUBLISH packets.
// ----------------------------------------------------------------------------
module mrd_parser import mrd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic [CfgDataW-1:0] max_topic,
	input  logic [CfgDataW-1:0] max_payload,
	output result_t             res
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_TLEN_HI,
		PH_TLEN_LO,
		PH_TOPIC,
		PH_PAYLOAD,
		PH_BODY,
		PH_ERROR
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [3:0]          type_q, type_d;
	logic [LenW-1:0]     left_q, left_d;
	logic [1:0]          lidx_q, lidx_d;
	logic [CountW-1:0]   tlen_q, tlen_d;
	logic [CountW-1:0]   tcount_q, tcount_d;
	logic [CountW-1:0]   pcount_q, pcount_d;
	logic                err_q, err_d;

	logic [LenW-1:0]     shifted;
	logic [LenW-1:0]     len_sum;
	logic [LenW-1:0]     left_dec;
	logic                body_end;
	logic [CountW-1:0]   tlen_full;
	logic [CountW-1:0]   tcount_inc;
	logic [CountW-1:0]   pcount_inc;

	// length group placed by its index, least significant group first
	always_comb begin
		case (lidx_q)
			2'd0: shifted = {21'd0, in_byte[6:0]};
			2'd1: shifted = {14'd0, in_byte[6:0], 7'd0};
			2'd2: shifted = {7'd0, in_byte[6:0], 14'd0};
			2'd3: shifted = {in_byte[6:0], 21'd0};
			default: shifted = '0;
		endcase
	end

	assign len_sum    = left_q + shifted;
	assign left_dec   = (left_q != '0) ? left_q - 1'b1 : '0;
	assign body_end   = (left_dec == '0);
	assign tlen_full  = tlen_q | {8'd0, in_byte};
	assign tcount_inc = (tcount_q != '1) ? tcount_q + 1'b1 : tcount_q;
	assign pcount_inc = (pcount_q != '1) ? pcount_q + 1'b1 : pcount_q;

	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		left_d   = left_q;
		lidx_d   = lidx_q;
		tlen_d   = tlen_q;
		tcount_d = tcount_q;
		pcount_d = pcount_q;
		err_d    = err_q;

		res.data_byte    = in_byte;
		res.byte_role    = ROLE_DISCARD;
		res.packet_end   = 1'b0;
		res.byte_kept    = 1'b0;
		res.malformed    = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				res.byte_role = ROLE_HEADER;
				type_d   = in_byte[7:4];
				left_d   = '0;
				lidx_d   = '0;
				tlen_d   = '0;
				tcount_d = '0;
				pcount_d = '0;
				phase_d  = PH_LENGTH;
			end
			PH_LENGTH: begin
				res.byte_role = ROLE_LENGTH;
				left_d = len_sum;
				if (in_byte[7]) begin
					if (lidx_q == 2'd3) begin
						err_d   = 1'b1;
						phase_d = PH_ERROR;
					end else begin
						lidx_d = lidx_q + 1'b1;
					end
				end else if (len_sum == '0) begin
					res.packet_end = 1'b1;
					phase_d        = PH_HEADER;
				end else if (type_q == TYPE_PUBLISH) begin
					if (len_sum < LenW'(2)) begin
						res.malformed = 1'b1;
						phase_d       = PH_BODY;
					end else begin
						phase_d = PH_TLEN_HI;
					end
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_TLEN_HI: begin
				res.byte_role  = ROLE_TLEN;
				tlen_d         = {in_byte, 8'd0};
				left_d         = left_dec;
				res.packet_end = body_end;
				phase_d        = body_end ? PH_HEADER : PH_TLEN_LO;
			end
			PH_TLEN_LO: begin
				res.byte_role  = ROLE_TLEN;
				tlen_d         = tlen_full;
				left_d         = left_dec;
				res.packet_end = body_end;
				if ({12'd0, tlen_full} > left_dec) begin
					res.malformed = 1'b1;
					phase_d       = body_end ? PH_HEADER : PH_BODY;
				end else if (body_end) begin
					phase_d = PH_HEADER;
				end else begin
					tcount_d = '0;
					if (tlen_full != '0) begin
						phase_d = PH_TOPIC;
					end else begin
						pcount_d = '0;
						phase_d  = PH_PAYLOAD;
					end
				end
			end
			PH_TOPIC: begin
				res.byte_role  = ROLE_TOPIC;
				res.byte_kept  = (tcount_q < max_topic);
				tcount_d       = tcount_inc;
				left_d         = left_dec;
				res.packet_end = body_end;
				if (body_end) begin
					phase_d = PH_HEADER;
				end else if (tcount_inc >= tlen_q) begin
					pcount_d = '0;
					phase_d  = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res.byte_role  = ROLE_PAYLOAD;
				res.byte_kept  = (pcount_q < max_payload);
				pcount_d       = pcount_inc;
				left_d         = left_dec;
				res.packet_end = body_end;
				if (body_end) begin
					phase_d = PH_HEADER;
				end
			end
			PH_BODY: begin
				res.byte_role  = ROLE_BODY;
				left_d         = left_dec;
				res.packet_end = body_end;
				if (body_end) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				res.byte_role = ROLE_DISCARD;
			end
		endcase

		res.packet_type  = type_d;
		res.length_error = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			type_q   <= '0;
			left_q   <= '0;
			lidx_q   <= '0;
			tlen_q   <= '0;
			tcount_q <= '0;
			pcount_q <= '0;
			err_q    <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			left_q   <= left_d;
			lidx_q   <= lidx_d;
			tlen_q   <= tlen_d;
			tcount_q <= tcount_d;
			pcount_q <= pcount_d;
			err_q    <= err_d;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("length error flag cleared");

	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) == err_q)
		else $error("error phase and error flag disagree");

	a_topic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TOPIC) |-> (tcount_q < tlen_q))
		else $error("topic walk past topic length");

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TLEN_HI || phase_q == PH_TLEN_LO || phase_q == PH_TOPIC ||
		 phase_q == PH_PAYLOAD || phase_q == PH_BODY) |-> (left_q != '0))
		else $error("body phase with no bytes left");

endmodule

// File: hw/rtl/mrd_result_reg.sv
// ----------------------------------------------------------------------------
// mrd_result_reg
// Result register of the deframer: holds one tagged word until the sink
// takes it, and tells the stage before when it may move on.
// ----------------------------------------------------------------------------
module mrd_result_reg import mrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  result_t   d,
	output logic      advance,
	mrd_out_if.source tx
);

	logic    valid_q;
	result_t data_q;

	assign advance = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			data_q <= d;
		end
	end

	assign tx.valid        = valid_q;
	assign tx.data_byte    = data_q.data_byte;
	assign tx.byte_role    = data_q.byte_role;
	assign tx.packet_type  = data_q.packet_type;
	assign tx.packet_end   = data_q.packet_end;
	assign tx.byte_kept    = data_q.byte_kept;
	assign tx.malformed    = data_q.malformed;
	assign tx.length_error = data_q.length_error;

endmodule
